[src/dlpm_pkg.sv]
// Shared types, constants and helper functions of the delay-line phase modulator.
// Used by every module of the block but the checker; depends on nothing else.
`default_nettype none

package dlpm_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FM_MODE   = 3'd0,
    CFG_ROUTING   = 3'd1,
    CFG_MOD_DEPTH = 3'd2,
    CFG_MOD_GAIN  = 3'd3,
    CFG_CAR_GAIN  = 3'd4,
    CFG_DRY_WET   = 3'd5,
    CFG_CAR_STEP  = 3'd6,
    CFG_MOD_STEP  = 3'd7
  } cfg_idx_e;

  // Modulation modes; the fourth code behaves like feedback mode.
  localparam logic [1:0] MODE_PHASE  = 2'd0;
  localparam logic [1:0] MODE_RING   = 2'd1;
  localparam logic [1:0] MODE_FB     = 2'd2;
  localparam logic [1:0] MODE_FB_ALT = 2'd3;

  // Carrier/modulator routing codes.
  localparam logic [1:0] ROUTE_MAIN_MAIN = 2'd0;
  localparam logic [1:0] ROUTE_SIDE_MAIN = 2'd1;
  localparam logic [1:0] ROUTE_SIDE_SIDE = 2'd2;
  localparam logic [1:0] ROUTE_MAIN_SIDE = 2'd3;

  // Fade gate phases; both upper codes mean open.
  localparam logic [1:0] PH_SILENT = 2'd0;
  localparam logic [1:0] PH_RAMP   = 2'd1;

  localparam logic signed [15:0] ACT_LIMIT = 16'sd16;
  localparam int unsigned        LEVEL_ONE = 65536;
  localparam int unsigned        DECAY_Q16 = 65077;
  localparam int                 FB_CLIP   = 24576;

  localparam logic [15:0] QSINE [65] = '{
    16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
    16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
    16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151,
    16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788,
    16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812,
    16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106,
    16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572,
    16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
    16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  typedef struct packed {
    logic [1:0]  fm_mode;
    logic [1:0]  routing;
    logic [15:0] mod_depth;
    logic [15:0] mod_gain;
    logic [15:0] car_gain;
    logic [8:0]  dry_wet;
    logic [17:0] car_step;
    logic [17:0] mod_step;
  } cfg_t;

  // One classified input item as it travels from front to back.
  typedef struct packed {
    logic               ch;
    logic signed [15:0] raw_car;
    logic signed [15:0] raw_mod;
    logic               car_act;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [16:0] level;
    logic [12:0] cnt;
  } gate_t;

  typedef struct packed {
    gate_t       st;
    logic [16:0] gain;
  } gate_res_t;

  typedef enum logic [3:0] {
    B_IDLE, B_GAIN, B_CAR, B_STORE, B_MOD, B_RING, B_OFF, B_POS,
    B_RED, B_RDA, B_RDB, B_INT1, B_INT2, B_MIX1, B_MIX2, B_OUT
  } bst_e;

  // One sample step of a fade gate.
  function automatic gate_res_t gate_tick(gate_t s, logic act, logic [17:0] step,
                                          logic [12:0] quiet);
    gate_res_t   r;
    logic [18:0] sum;
    logic [12:0] cnt1;
    r    = '{st: s, gain: '0};
    sum  = {2'b00, s.level} + {1'b0, step};
    cnt1 = s.cnt + 13'd1;
    case (s.phase)
      PH_SILENT: begin
        if (act) begin
          r.st.phase = PH_RAMP;
          r.st.level = '0;
          r.st.cnt   = '0;
        end
      end
      PH_RAMP: begin
        if (!act) begin
          r.st = '0;
        end else if (sum >= 19'(LEVEL_ONE)) begin
          r.st.level = 17'(LEVEL_ONE);
          r.st.phase = 2'd2;
          r.st.cnt   = '0;
          r.gain     = 17'(LEVEL_ONE);
        end else begin
          r.st.level = sum[16:0];
          r.gain     = sum[16:0];
        end
      end
      default: begin
        r.gain = 17'(LEVEL_ONE);
        if (act) begin
          r.st.cnt = '0;
        end else if (cnt1 >= quiet) begin
          r.st = '0;
        end else begin
          r.st.cnt = cnt1;
        end
      end
    endcase
    return r;
  endfunction

  // Equal-power mix gain for a position of 0 to 256, Q1.15.
  function automatic logic [16:0] mix_gain(logic [8:0] p);
    logic [6:0]  i;
    logic [1:0]  f;
    logic [15:0] d;
    logic [17:0] t;
    i = p[8:2];
    f = p[1:0];
    if (i >= 7'd64) begin
      return 17'd32768;
    end
    d = QSINE[7'(i + 7'd1)] - QSINE[i];
    t = 18'(d) * 18'(f) + 18'd2;
    return 17'(QSINE[i]) + 17'(t[17:2]);
  endfunction

endpackage

`default_nettype wire

[src/delay_line_phase_modulator.sv]
// Delay-line phase modulator with ring and feedback modes, per stereo channel.
// A phase or feedback beat passes through the offset wrap in the back-end sequencer
// (seven conditional subtract steps) and two reads of the single delay-memory port;
// a ring beat skips both. A two-entry queue lets the input side take up to two beats
// while one is being processed and a result waits to be taken.
// The delay lines read as zero until written; write tracking replaces a clearing pass,
// so the block is ready right after reset. Depends on dlpm_pkg and the dlpm_ modules.
`default_nettype none

module delay_line_phase_modulator #(
  parameter int DELAY_DEPTH   = 4096,
  parameter int BASE_DELAY    = 1024,
  parameter int QUIET_SAMPLES = 4800,
  parameter int CHANNELS      = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // channel, main_sample, side_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // out_sample
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [17:0] cfg_wdata_i
);
  import dlpm_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push_valid, fifo_full, fifo_valid, fifo_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fm_mode   <= MODE_PHASE;
      cfg_q.routing   <= ROUTE_MAIN_SIDE;
      cfg_q.mod_depth <= 16'd3200;
      cfg_q.mod_gain  <= 16'd4096;
      cfg_q.car_gain  <= 16'd16384;
      cfg_q.dry_wet   <= 9'd128;
      cfg_q.car_step  <= 18'd131072;
      cfg_q.mod_step  <= 18'd131072;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FM_MODE:   cfg_q.fm_mode   <= cfg_wdata_i[1:0];
        CFG_ROUTING:   cfg_q.routing   <= cfg_wdata_i[1:0];
        CFG_MOD_DEPTH: cfg_q.mod_depth <= cfg_wdata_i[15:0];
        CFG_MOD_GAIN:  cfg_q.mod_gain  <= cfg_wdata_i[15:0];
        CFG_CAR_GAIN:  cfg_q.car_gain  <= cfg_wdata_i[15:0];
        CFG_DRY_WET:   cfg_q.dry_wet   <= cfg_wdata_i[8:0];
        CFG_CAR_STEP:  cfg_q.car_step  <= cfg_wdata_i;
        CFG_MOD_STEP:  cfg_q.mod_step  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dlpm_front #(.CHANNELS(CHANNELS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .routing_i     (cfg_q.routing),
    .push_valid_o  (push_valid),
    .push_ready_i  (!fifo_full),
    .push_item_o   (push_item)
  );

  dlpm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .pop_i       (fifo_pop),
    .pop_item_o  (pop_item)
  );

  dlpm_back #(
    .DELAY_DEPTH   (DELAY_DEPTH),
    .BASE_DELAY    (BASE_DELAY),
    .QUIET_SAMPLES (QUIET_SAMPLES),
    .CHANNELS      (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (fifo_valid),
    .q_pop_o       (fifo_pop),
    .q_item_i      (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[src/dlpm_front.sv]
// Front end: accepts input beats, picks carrier and modulator and classifies them.
// Depends on dlpm_pkg.
`default_nettype none

module dlpm_front #(
  parameter int CHANNELS = 2
) (
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [39:0]      s_axis_tdata,   // channel, main_sample, side_sample
  input  wire logic [1:0]       routing_i,
  output logic                  push_valid_o,
  input  wire logic             push_ready_i,
  output dlpm_pkg::item_t       push_item_o
);
  import dlpm_pkg::*;

  logic               chan;
  logic signed [15:0] main_s;
  logic signed [15:0] side_s;
  logic signed [15:0] car_s;
  logic signed [15:0] mod_s;

  always_comb begin
    chan   = s_axis_tdata[0];
    main_s = s_axis_tdata[16:1];
    side_s = s_axis_tdata[32:17];
    car_s  = (routing_i == ROUTE_SIDE_MAIN || routing_i == ROUTE_SIDE_SIDE) ? side_s : main_s;
    mod_s  = (routing_i == ROUTE_SIDE_SIDE || routing_i == ROUTE_MAIN_SIDE) ? side_s : main_s;
    // An out-of-range channel folds onto the last one.
    push_item_o.ch      = (32'(chan) >= CHANNELS) ? 1'(CHANNELS - 1) : chan;
    push_item_o.raw_car = car_s;
    push_item_o.raw_mod = mod_s;
    push_item_o.car_act = (car_s > ACT_LIMIT) || (car_s < -ACT_LIMIT);
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

`default_nettype wire

[src/dlpm_fifo.sv]
// Two-entry queue of classified items between front and back.
// Depends on dlpm_pkg.
`default_nettype none

module dlpm_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dlpm_pkg::item_t push_item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output dlpm_pkg::item_t      pop_item_o
);
  import dlpm_pkg::*;

  item_t      data_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_item_o = data_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) data_q[wr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

[src/dlpm_back.sv]
// Back end: fade gates, delay line, modulation arithmetic and dry/wet mix.
// Holds the delay memory and per-channel state; depends on dlpm_pkg.
`default_nettype none

module dlpm_back #(
  parameter int DELAY_DEPTH   = 4096,
  parameter int BASE_DELAY    = 1024,
  parameter int QUIET_SAMPLES = 4800,
  parameter int CHANNELS      = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dlpm_pkg::cfg_t  cfg_i,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  input  wire dlpm_pkg::item_t q_item_i,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [15:0]          m_axis_tdata    // out_sample
);
  import dlpm_pkg::*;

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int MW    = $clog2(CHANNELS * DELAY_DEPTH);
  localparam int RED_K = 6;
  localparam int VW    = AW + 8;

  bst_e state_q, state_d;

  // Per-channel state.
  logic [AW-1:0]      wp_q   [CHANNELS];
  logic               wrap_q [CHANNELS];
  gate_t              carg_q [CHANNELS];
  gate_t              modg_q [CHANNELS];
  logic signed [15:0] fb_q   [CHANNELS];
  logic [15:0]        mem_q  [CHANNELS * DELAY_DEPTH];

  // Item datapath.
  item_t              item_q;
  logic [16:0]        cg_q, mg_q;
  logic signed [32:0] pc_q, pm_q;
  logic signed [15:0] modsig_q;
  logic signed [50:0] cw_q, mw_q;
  logic signed [15:0] carrier_q;
  logic signed [20:0] mod_q;
  logic signed [32:0] off_q;
  logic [VW-1:0]      v_q;
  logic [15:0]        frac_q;
  logic [2:0]         k_q;
  logic signed [15:0] rd_q, a_q, b_q;
  logic signed [34:0] acc_q;
  logic signed [22:0] wet_q;
  logic signed [32:0] t1_q;
  logic [15:0]        res_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  logic               fb_mode;
  logic [8:0]         pos;
  logic [16:0]        gw, gd;
  gate_res_t          car_res, mod_res;
  logic signed [16:0] fbx, mag, decm;
  logic [33:0]        dec;
  logic signed [15:0] decayed;
  logic signed [50:0] cw_rnd;
  logic signed [20:0] car_wide;
  logic signed [15:0] carrier;
  logic [AW-1:0]      ia, ib;
  logic [AW-1:0]      wp_cur;
  logic               va, vb;
  logic [MW-1:0]      base_addr, rd_addr;
  logic [VW:0]        vinit;
  logic [VW-1:0]      sub;
  logic signed [37:0] offp;
  logic signed [36:0] ringp;
  logic signed [34:0] ints;
  logic signed [40:0] mixs;
  logic signed [25:0] mixr;
  logic signed [25:0] lim_hi, lim_lo;
  logic               out_load;

  assign fb_mode = (cfg_i.fm_mode == MODE_FB) || (cfg_i.fm_mode == MODE_FB_ALT);
  assign pos     = (cfg_i.dry_wet > 9'd256) ? 9'd256 : cfg_i.dry_wet;
  assign gw      = mix_gain(pos);
  assign gd      = mix_gain(9'd256 - pos);
  assign wp_cur  = wp_q[item_q.ch];

  always_comb begin
    car_res = gate_tick(carg_q[item_q.ch], item_q.car_act, cfg_i.car_step,
                        13'(QUIET_SAMPLES));
    mod_res = gate_tick(modg_q[item_q.ch],
                        (modsig_q > ACT_LIMIT) || (modsig_q < -ACT_LIMIT),
                        cfg_i.mod_step, 13'(QUIET_SAMPLES));
    // Feedback decays by 0.993 on the magnitude, sign kept.
    fbx     = 17'(fb_q[item_q.ch]);
    mag     = fbx[16] ? -fbx : fbx;
    dec     = 34'($unsigned(mag)) * 34'(DECAY_Q16);
    decm    = $signed(dec[32:16]);
    decayed = fbx[16] ? 16'(-decm) : 16'(decm);
    cw_rnd  = cw_q + 51'sd536870912;
    car_wide = 21'(cw_rnd >>> 30);
    if (car_wide > 21'sd32767) begin
      carrier = 16'sd32767;
    end else if (car_wide < -21'sd32768) begin
      carrier = -16'sd32768;
    end else begin
      carrier = 16'(car_wide);
    end
    ia   = v_q[AW-1:0];
    ib   = (ia == AW'(DELAY_DEPTH - 1)) ? '0 : ia + AW'(1);
    va   = wrap_q[item_q.ch] || (ia <= wp_cur);
    vb   = wrap_q[item_q.ch] || (ib <= wp_cur);
    base_addr = item_q.ch ? MW'(DELAY_DEPTH) : '0;
    rd_addr   = base_addr + MW'((state_q == B_RDA) ? ia : ib);
    vinit = (VW+1)'(wp_cur) - (VW+1)'(BASE_DELAY) + (VW+1)'(off_q >>> 16)
          + (VW+1)'(DELAY_DEPTH * (2 ** RED_K));
    sub   = VW'(DELAY_DEPTH) << k_q;
    offp  = mod_q * $signed({1'b0, cfg_i.mod_depth});
    ringp = carrier_q * mod_q;
    ints  = acc_q + b_q * $signed({1'b0, frac_q});
    mixs  = 41'(t1_q) + wet_q * $signed({1'b0, gw});
    mixr  = 26'((mixs + 41'sd16384) >>> 15);
    lim_hi = fb_mode ? 26'(FB_CLIP) : 26'sd32767;
    lim_lo = fb_mode ? -26'(FB_CLIP) : -26'sd32768;
  end

  assign out_load = (state_q == B_OUT) && (!out_valid_q || m_axis_tready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = B_GAIN;
        end
      end
      B_GAIN:  state_d = B_CAR;
      B_CAR:   state_d = B_STORE;
      B_STORE: state_d = B_MOD;
      B_MOD:   state_d = (cfg_i.fm_mode == MODE_RING) ? B_RING : B_OFF;
      B_RING:  state_d = B_MIX1;
      B_OFF:   state_d = B_POS;
      B_POS:   state_d = B_RED;
      B_RED:   if (k_q == 3'd0) state_d = B_RDA;
      B_RDA:   state_d = B_RDB;
      B_RDB:   state_d = B_INT1;
      B_INT1:  state_d = B_INT2;
      B_INT2:  state_d = B_MIX1;
      B_MIX1:  state_d = B_MIX2;
      B_MIX2:  state_d = B_OUT;
      B_OUT:   if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]   <= '0;
        wrap_q[c] <= 1'b0;
        carg_q[c] <= '0;
        modg_q[c] <= '0;
        fb_q[c]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_GAIN) carg_q[item_q.ch] <= car_res.st;
      if (state_q == B_CAR)  modg_q[item_q.ch] <= mod_res.st;
      // The wet value of this beat is in wet_q from the first mix cycle on.
      if (state_q == B_MIX1 && fb_mode) fb_q[item_q.ch] <= 16'(wet_q);
      if (out_load) begin
        if (wp_cur == AW'(DELAY_DEPTH - 1)) begin
          wp_q[item_q.ch]   <= '0;
          wrap_q[item_q.ch] <= 1'b1;
        end else begin
          wp_q[item_q.ch] <= wp_cur + AW'(1);
        end
      end
    end
  end

  // Delay memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == B_STORE) mem_q[base_addr + MW'(wp_cur)] <= carrier;
    rd_q <= mem_q[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: item_q <= q_item_i;
      B_GAIN: begin
        pc_q     <= item_q.raw_car * $signed({1'b0, cfg_i.car_gain});
        cg_q     <= car_res.gain;
        modsig_q <= fb_mode ? (item_q.car_act ? fb_q[item_q.ch] : decayed) : item_q.raw_mod;
      end
      B_CAR: begin
        cw_q <= pc_q * $signed({1'b0, cg_q});
        mg_q <= mod_res.gain;
        pm_q <= modsig_q * $signed({1'b0, cfg_i.mod_gain});
      end
      B_STORE: begin
        carrier_q <= carrier;
        mw_q      <= pm_q * $signed({1'b0, mg_q});
      end
      B_MOD:  mod_q <= 21'((mw_q + 51'sd134217728) >>> 28);
      B_RING: wet_q <= 23'((ringp + 37'sd8192) >>> 14);
      B_OFF:  off_q <= 33'(offp >>> 5);
      B_POS: begin
        v_q    <= vinit[VW-1:0];
        frac_q <= off_q[15:0];
        k_q    <= 3'(RED_K);
      end
      B_RED: begin
        if (v_q >= sub) v_q <= v_q - sub;
        if (k_q != 3'd0) k_q <= k_q - 3'd1;
      end
      B_RDB:  a_q <= va ? rd_q : '0;
      B_INT1: begin
        b_q   <= vb ? rd_q : '0;
        acc_q <= a_q * $signed(18'(32'd65536 - 32'(frac_q)));
      end
      B_INT2: wet_q <= 23'(16'((ints + 35'sd32768) >>> 16));
      B_MIX1: t1_q <= carrier_q * $signed({1'b0, gd});
      B_MIX2: begin
        if (mixr > lim_hi) begin
          res_q <= 16'(lim_hi);
        end else if (mixr < lim_lo) begin
          res_q <= 16'(lim_lo);
        end else begin
          res_q <= 16'(mixr);
        end
      end
      B_OUT: if (out_load) out_data_q <= res_q;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[src/dlpm_checker.sv]
// Port-level checks of the modulator's streams, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module dlpm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // Beats accepted but not yet delivered.
  logic [2:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + 3'(s_axis_tvalid && s_axis_tready)
                       - 3'(m_axis_tvalid && m_axis_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("output beat without a pending input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more beats in flight than the block can hold");

endmodule

bind delay_line_phase_modulator dlpm_checker u_dlpm_checker (.*);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for delay_line_phase_modulator: drives sample beats and
// register writes, predicts each output with a behavioral model. Depends on dlpm_pkg.
`default_nettype none

module testbench;
  import dlpm_pkg::*;

  localparam int DEPTH     = 4096;
  localparam int BASE      = 1024;
  localparam int QUIET     = 4800;
  localparam int LIMIT_CYC = 2000000;

  localparam int QS [65] = '{
    0, 804, 1608, 2411, 3212, 4011, 4808, 5602, 6393, 7180,
    7962, 8740, 9512, 10279, 11039, 11793, 12540, 13279, 14010, 14733,
    15447, 16151, 16846, 17531, 18205, 18868, 19520, 20160, 20788, 21403,
    22006, 22595, 23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957, 30274, 30572,
    30853, 31114, 31357, 31581, 31786, 31972, 32138, 32286, 32413, 32522,
    32610, 32679, 32729, 32758, 32768
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // channel, main_sample, side_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // out_sample
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [17:0] cfg_wdata_i;

  delay_line_phase_modulator uut (.*);

  // Predictor state.
  logic [1:0]  m_mode, m_route;
  logic [15:0] m_depth, m_mgain, m_cgain;
  logic [8:0]  m_mix;
  logic [17:0] m_cstep, m_mstep;
  logic signed [15:0] line_mem [2][DEPTH];
  int unsigned wpos [2];
  int unsigned cph [2], clv [2], ccnt [2];
  int unsigned mph [2], mlv [2], mcnt [2];
  int          fbv [2];

  logic [15:0] expected_q [$];
  int          errors, checked, sent, cycles;
  int          stall_left;
  logic        idle_en;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** delay_line_phase_modulator: FAILED **");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit loud(int x);
    return x > 16 || x < -16;
  endfunction

  function automatic int unsigned fade_step(inout int unsigned ph, inout int unsigned lv,
                                            inout int unsigned cnt, input int x,
                                            input int unsigned st);
    bit act;
    act = loud(x);
    if (ph == 0) begin
      if (act) begin
        ph = 1; lv = 0; cnt = 0;
      end
      return 0;
    end
    if (ph == 1) begin
      if (!act) begin
        ph = 0; lv = 0; cnt = 0;
        return 0;
      end
      lv = lv + st;
      if (lv >= 65536) begin
        lv = 65536; ph = 2; cnt = 0;
      end
      return lv;
    end
    if (act) cnt = 0;
    else begin
      cnt = cnt + 1;
      if (cnt >= QUIET) begin
        ph = 0; lv = 0; cnt = 0;
      end
    end
    return 65536;
  endfunction

  function automatic int tap_read(int ch, longint md);
    longint span, pos, f, acc;
    int ia, ib;
    span = longint'(DEPTH) * 65536;
    pos = (longint'(wpos[ch]) - BASE) * 65536 + floor_sh(md * longint'(m_depth), 5);
    pos = pos % span;
    if (pos < 0) pos += span;
    ia = int'(pos >> 16);
    ib = (ia + 1) % DEPTH;
    f = pos & 64'hFFFF;
    acc = longint'(line_mem[ch][ia]) * (65536 - f) + longint'(line_mem[ch][ib]) * f;
    return int'(rnd_sh(acc, 16));
  endfunction

  function automatic longint eq_gain(int p);
    int i, f;
    i = p >> 2;
    f = p & 3;
    if (i >= 64) return 32768;
    return QS[i] + (((QS[i + 1] - QS[i]) * f + 2) >> 2);
  endfunction

  function automatic logic [15:0] predict_sample(logic ch, logic signed [15:0] ms,
                                                 logic signed [15:0] ss);
    int rc, rm, c, fb, p;
    int unsigned cg, mg, mag;
    longint car, md, wet, res;
    c  = ch;
    rc = (m_route == ROUTE_SIDE_MAIN || m_route == ROUTE_SIDE_SIDE) ? ss : ms;
    rm = (m_route >= ROUTE_SIDE_SIDE) ? ss : ms;
    cg = fade_step(cph[c], clv[c], ccnt[c], rc, m_cstep);
    car = clip(rnd_sh(longint'(rc) * m_cgain * cg, 30), -32768, 32767);
    line_mem[c][wpos[c]] = 16'(car);
    if (m_mode < MODE_FB) begin
      mg = fade_step(mph[c], mlv[c], mcnt[c], rm, m_mstep);
      md = rnd_sh(longint'(rm) * m_mgain * mg, 28);
      if (m_mode == MODE_PHASE) wet = tap_read(c, md);
      else wet = rnd_sh(car * md, 14);
    end else begin
      fb = fbv[c];
      if (!loud(rc)) begin
        mag = fb < 0 ? -fb : fb;
        mag = int'((longint'(mag) * DECAY_Q16) >> 16);
        fb = fb < 0 ? -int'(mag) : int'(mag);
      end
      mg = fade_step(mph[c], mlv[c], mcnt[c], fb, m_mstep);
      md = rnd_sh(longint'(fb) * m_mgain * mg, 28);
      wet = tap_read(c, md);
      fbv[c] = int'(wet);
    end
    p = m_mix > 256 ? 256 : m_mix;
    res = rnd_sh(car * eq_gain(256 - p) + wet * eq_gain(p), 15);
    if (m_mode >= MODE_FB) res = clip(res, -FB_CLIP, FB_CLIP);
    res = clip(res, -32768, 32767);
    wpos[c] = (wpos[c] + 1) % DEPTH;
    return 16'(res);
  endfunction

  task automatic idle_burst();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Valid stays high after a beat so the next one can follow without a gap.
  task automatic send_sample(logic ch, logic [15:0] ms, logic [15:0] ss);
    idle_burst();
    expected_q.insert(expected_q.size(), predict_sample(ch, ms, ss));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ss, ms, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_reg(cfg_idx_e idx, logic [17:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FM_MODE:   m_mode  = val[1:0];
      CFG_ROUTING:   m_route = val[1:0];
      CFG_MOD_DEPTH: m_depth = val[15:0];
      CFG_MOD_GAIN:  m_mgain = val[15:0];
      CFG_CAR_GAIN:  m_cgain = val[15:0];
      CFG_DRY_WET:   m_mix   = val[8:0];
      CFG_CAR_STEP:  m_cstep = val;
      CFG_MOD_STEP:  m_mstep = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output beat %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch on beat %0d: expected %h, got %h", checked, expected_q[0],
                     m_axis_tdata);
        end
        void'(expected_q.pop_front());
        checked++;
      end
    end
  end

  // Output back-pressure in random bursts while idle_en is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_axis_tready <= 1'b1;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= int'($urandom_range(1, 15));
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 32)) - 16'd16;
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] v [6] = '{16'h7FFF, 16'h8000, 16'h0010, 16'hFFEF, 16'h0011, 16'h0000};
    foreach (v[i]) send_sample(i[0], v[i], v[5 - i]);
    write_reg(CFG_DRY_WET, 18'd511);
    write_reg(CFG_CAR_GAIN, 18'd32768);
    write_reg(CFG_MOD_DEPTH, 18'd64000);
    write_reg(CFG_MOD_GAIN, 18'd49152);
    foreach (v[i]) send_sample(1'b0, v[i], 16'h8000);
    write_reg(CFG_FM_MODE, 18'(MODE_RING));
    foreach (v[i]) send_sample(1'b1, 16'h7FFF, v[i]);
    write_reg(CFG_FM_MODE, 18'(MODE_FB_ALT));
    repeat (4) send_sample(1'b0, 16'h7FFF, 16'h7FFF);
    repeat (3) send_sample(1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_config_sweep();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FM_MODE, 18'($urandom_range(0, 3)));
      write_reg(CFG_ROUTING, 18'($urandom_range(0, 3)));
      write_reg(CFG_MOD_DEPTH, ph == 0 ? 18'd0 : 18'($urandom_range(0, 65535)));
      write_reg(CFG_MOD_GAIN, ph == 1 ? 18'd0 : 18'($urandom_range(0, 65535)));
      write_reg(CFG_CAR_GAIN, 18'($urandom_range(0, 65535)));
      write_reg(CFG_DRY_WET, ph == 2 ? 18'd0 : 18'($urandom_range(0, 511)));
      write_reg(CFG_CAR_STEP, ph == 3 ? 18'd0 : 18'($urandom_range(0, 1) ?
                $urandom_range(1, 20000) : $urandom));
      write_reg(CFG_MOD_STEP, ph == 4 ? 18'd0 : 18'($urandom_range(0, 1) ?
                $urandom_range(1, 20000) : $urandom));
      if (ph == 7) idle_en = 1'b0;
      repeat (60) send_sample(1'($urandom), rand_sample(), rand_sample());
    end
  endtask

  // Quiet stretches keep an open gate open and count up; a loud beat clears the count.
  task automatic test_quiet_hold();
    write_reg(CFG_FM_MODE, 18'(MODE_PHASE));
    write_reg(CFG_ROUTING, 18'(ROUTE_MAIN_MAIN));
    write_reg(CFG_CAR_STEP, 18'd131072);
    write_reg(CFG_MOD_STEP, 18'd30000);
    send_sample(1'b1, 16'h4000, 16'h0);
    repeat (40) send_sample(1'b1, 16'h0003, 16'h0);
    send_sample(1'b1, 16'h2000, 16'h0);
    repeat (20) send_sample(1'b1, 16'hFFF0, 16'h0);
    repeat (5) send_sample(1'b1, 16'hC000, 16'h0);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_addr_i = '0; cfg_wdata_i = '0;
    errors = 0; checked = 0; sent = 0; cycles = 0; idle_en = 1'b1;
    m_mode = MODE_PHASE; m_route = ROUTE_MAIN_SIDE; m_depth = 16'd3200;
    m_mgain = 16'd4096; m_cgain = 16'd16384; m_mix = 9'd128;
    m_cstep = 18'd131072; m_mstep = 18'd131072;
    for (int c = 0; c < 2; c++) begin
      wpos[c] = 0; cph[c] = 0; clv[c] = 0; ccnt[c] = 0;
      mph[c] = 0; mlv[c] = 0; mcnt[c] = 0; fbv[c] = 0;
      for (int k = 0; k < DEPTH; k++) line_mem[c][k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_quiet_hold();
    idle_en = 1'b1;
    test_config_sweep();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d sample beats, checked %0d outputs over all modes, routings", sent,
             checked);
    $display("and register extremes, with %0d mismatches.", errors);
    if (errors == 0 && expected_q.size() == 0) $display("** delay_line_phase_modulator: PASSED **");
    else $display("** delay_line_phase_modulator: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
